// ===== rtl/core/setpoint_slew_and_window_top_assert.svh =====
// Assertion macros of the setpoint slew and window checker.
`ifndef SETPOINT_SLEW_AND_WINDOW_TOP_ASSERT_SVH
`define SETPOINT_SLEW_AND_WINDOW_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising edge, off during reset.
`define SPSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spsw check failed");

// Next-cycle implication, checked on the rising edge, off during reset.
`define SPSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spsw check failed");

`endif

// ===== rtl/core/spsw_pkg.sv =====
// Shared types and constants of the setpoint slew and window block.
package spsw_pkg;

    localparam int unsigned LenW   = 17;
    localparam int unsigned WinW   = 31;
    localparam int unsigned DataW  = 32;
    localparam int unsigned CfgAw  = 3;
    localparam int unsigned MulAw  = 33;
    localparam int unsigned MulBw  = 18;
    localparam int unsigned ProdW  = MulAw + MulBw;

    localparam logic [CfgAw-1:0] CFG_REF_LEN   = 3'd0;
    localparam logic [CfgAw-1:0] CFG_SLOPE     = 3'd1;
    localparam logic [CfgAw-1:0] CFG_BASE_STEP = 3'd2;
    localparam logic [CfgAw-1:0] CFG_TICK      = 3'd3;
    localparam logic [CfgAw-1:0] CFG_POS_WIN   = 3'd4;
    localparam logic [CfgAw-1:0] CFG_SPD_WIN   = 3'd5;

    localparam logic [LenW-1:0] RST_REF_LEN   = 17'd4588;
    localparam logic [LenW-1:0] RST_SLOPE     = 17'd1311;
    localparam logic [LenW-1:0] RST_BASE_STEP = 17'd131;
    localparam logic [LenW-1:0] RST_TICK      = 17'd262;
    localparam logic [WinW-1:0] RST_POS_WIN   = 31'd6554;
    localparam logic [WinW-1:0] RST_SPD_WIN   = 31'd19661;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_STEP,
        ST_SLEW,
        ST_MUL_POS,
        ST_POS,
        ST_WIN
    } state_t;

    typedef enum logic [1:0] {
        MUL_SEL_STEP,
        MUL_SEL_YAW,
        MUL_SEL_POS
    } mul_sel_t;

    typedef struct packed {
        logic     ready;
        logic     accept;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     step_load;
        logic     slew_load;
        logic     pos_load;
        logic     finish;
    } ctrl_t;

endpackage

// ===== rtl/core/setpoint_slew_and_window_top.sv =====
// Top level of the setpoint slew limiter with tracking windows.
//
// One input word is one control tick. The block accepts it, then walks it
// through the sequencer before the result word appears on m_tdata: the
// single 33x18 multiplier is used three times in turn (ramp-step slope, yaw
// increment, position increment), with the slew, integrate and window steps
// among and after them. s_tready is high only while the sequencer is idle,
// so a new word is taken only after the previous one has left the window
// step. A finished result sits in the output register while the next
// word is accepted; the block stalls at the window step only if that
// register is still full. Configuration writes take effect at once and
// must come while no tick is in progress.
module setpoint_slew_and_window_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata, lowest bit up: left_leg_length, right_leg_length, speed_command,
    // yaw_rate_command, measured_position, measured_speed
    input  logic [6*spsw_pkg::DataW-1:0]      s_tdata,
    // s_tuser: reload
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata, lowest bit up: target_speed, target_position, target_yaw
    output logic [3*spsw_pkg::DataW-1:0]      m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [spsw_pkg::CfgAw-1:0]        cfg_addr,
    input  logic [spsw_pkg::WinW-1:0]         cfg_wdata
);

    localparam logic signed [37:0] SatHi = 38'sd2147483647;
    localparam logic signed [37:0] SatLo = -38'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > SatHi)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SatLo)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] win_sat(input logic signed [35:0] v,
                                                   input logic signed [31:0] c,
                                                   input logic [30:0] w);
        logic signed [37:0] vx;
        logic signed [37:0] cx;
        logic signed [37:0] wx;
        logic signed [37:0] d;
        logic signed [37:0] r;
        vx = {{2{v[35]}}, v};
        cx = {{6{c[31]}}, c};
        wx = {7'd0, w};
        d  = vx - cx;
        if (d > wx)
        begin
            r = cx + wx;
        end
        else if (d < -wx)
        begin
            r = cx - wx;
        end
        else
        begin
            r = vx;
        end
        return sat32(r);
    endfunction

    spsw_pkg::ctrl_t ctrl;

    logic                         m_tvalid_reg;
    logic                         out_free;

    // configuration
    logic [spsw_pkg::LenW-1:0]    ref_len_reg;
    logic [spsw_pkg::LenW-1:0]    slope_reg;
    logic [spsw_pkg::LenW-1:0]    base_step_reg;
    logic [spsw_pkg::LenW-1:0]    tick_reg;
    logic [spsw_pkg::WinW-1:0]    pos_win_reg;
    logic [spsw_pkg::WinW-1:0]    spd_win_reg;

    // tick state
    logic signed [31:0]           speed_target_reg;
    logic signed [31:0]           position_target_reg;
    logic [31:0]                  yaw_target_reg;

    // per-word working registers
    logic signed [32:0]           dev_reg;
    logic signed [31:0]           cmd_reg;
    logic signed [31:0]           yaw_rate_reg;
    logic signed [31:0]           meas_pos_reg;
    logic signed [31:0]           meas_spd_reg;
    logic [34:0]                  step_reg;
    logic signed [31:0]           spd_reg;
    logic signed [35:0]           pos_reg;
    logic [3*spsw_pkg::DataW-1:0] m_tdata_reg;

    logic signed [31:0]           in_left;
    logic signed [31:0]           in_right;
    logic signed [32:0]           leg_sum;
    logic signed [32:0]           dev_next;

    logic signed [spsw_pkg::MulAw-1:0] mul_a;
    logic signed [spsw_pkg::MulBw-1:0] mul_b;
    logic signed [spsw_pkg::ProdW-1:0] prod;
    logic signed [spsw_pkg::ProdW-1:0] prod_biased;
    logic signed [34:0]                prod_rnd;

    logic signed [36:0]           step_raw;
    logic [34:0]                  step_next;
    logic signed [33:0]           diff;
    logic [33:0]                  abs_diff;
    logic signed [36:0]           slew_sum;
    logic signed [31:0]           spd_next;
    logic signed [35:0]           pos_next;
    logic signed [31:0]           pos_final;
    logic signed [31:0]           spd_final;

    spsw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    spsw_mul u_mul
    (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_tready = ctrl.ready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // average the legs and take the offset from the reference length
    assign in_left  = s_tdata[31:0];
    assign in_right = s_tdata[63:32];
    assign leg_sum  = {in_left[31], in_left} + {in_right[31], in_right};
    assign dev_next = {leg_sum[32], leg_sum[32:1]} - {16'd0, ref_len_reg};

    always_comb
    begin
        mul_a = dev_reg;
        mul_b = {1'b0, slope_reg};
        unique case (ctrl.mul_sel)
            spsw_pkg::MUL_SEL_STEP:
            begin
                mul_a = dev_reg;
                mul_b = {1'b0, slope_reg};
            end
            spsw_pkg::MUL_SEL_YAW:
            begin
                mul_a = {yaw_rate_reg[31], yaw_rate_reg};
                mul_b = {1'b0, tick_reg};
            end
            spsw_pkg::MUL_SEL_POS:
            begin
                mul_a = {spd_reg[31], spd_reg};
                mul_b = {1'b0, tick_reg};
            end
            default:
            begin
                mul_a = dev_reg;
                mul_b = {1'b0, slope_reg};
            end
        endcase
    end

    // round half up, drop 16 fraction bits
    assign prod_biased = prod + spsw_pkg::ProdW'(32768);
    assign prod_rnd    = prod_biased[spsw_pkg::ProdW-1:16];

    // ramp step, floored at zero
    assign step_raw  = {20'd0, base_step_reg} - {{2{prod_rnd[34]}}, prod_rnd};
    assign step_next = step_raw[36] ? 35'd0 : step_raw[34:0];

    // slew toward the command
    assign diff     = {{2{cmd_reg[31]}}, cmd_reg} - {{2{speed_target_reg[31]}}, speed_target_reg};
    assign abs_diff = diff[33] ? 34'(-diff) : 34'(diff);

    always_comb
    begin
        if (diff > 34'sd0)
        begin
            slew_sum = {{5{speed_target_reg[31]}}, speed_target_reg} + {2'b00, step_reg};
        end
        else
        begin
            slew_sum = {{5{speed_target_reg[31]}}, speed_target_reg} - {2'b00, step_reg};
        end
        if ({1'b0, abs_diff} < step_reg)
        begin
            spd_next = cmd_reg;
        end
        else
        begin
            spd_next = sat32({slew_sum[36], slew_sum});
        end
    end

    assign pos_next  = {{4{position_target_reg[31]}}, position_target_reg}
                     + {prod_rnd[34], prod_rnd};
    assign pos_final = win_sat(pos_reg, meas_pos_reg, pos_win_reg);
    assign spd_final = win_sat({{4{spd_reg[31]}}, spd_reg}, meas_spd_reg, spd_win_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_len_reg   <= spsw_pkg::RST_REF_LEN;
            slope_reg     <= spsw_pkg::RST_SLOPE;
            base_step_reg <= spsw_pkg::RST_BASE_STEP;
            tick_reg      <= spsw_pkg::RST_TICK;
            pos_win_reg   <= spsw_pkg::RST_POS_WIN;
            spd_win_reg   <= spsw_pkg::RST_SPD_WIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                spsw_pkg::CFG_REF_LEN:   ref_len_reg   <= cfg_wdata[spsw_pkg::LenW-1:0];
                spsw_pkg::CFG_SLOPE:     slope_reg     <= cfg_wdata[spsw_pkg::LenW-1:0];
                spsw_pkg::CFG_BASE_STEP: base_step_reg <= cfg_wdata[spsw_pkg::LenW-1:0];
                spsw_pkg::CFG_TICK:      tick_reg      <= cfg_wdata[spsw_pkg::LenW-1:0];
                spsw_pkg::CFG_POS_WIN:   pos_win_reg   <= cfg_wdata;
                spsw_pkg::CFG_SPD_WIN:   spd_win_reg   <= cfg_wdata;
                default:                 ref_len_reg   <= ref_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_target_reg    <= '0;
            position_target_reg <= '0;
            yaw_target_reg      <= '0;
            m_tvalid_reg        <= 1'b0;
        end
        else
        begin
            if (ctrl.finish)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (ctrl.accept && s_tuser)
            begin
                position_target_reg <= s_tdata[159:128];
                speed_target_reg    <= '0;
            end
            if (ctrl.slew_load)
            begin
                yaw_target_reg <= yaw_target_reg + prod_rnd[31:0];
            end
            if (ctrl.finish)
            begin
                position_target_reg <= pos_final;
                speed_target_reg    <= spd_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            dev_reg      <= dev_next;
            cmd_reg      <= s_tdata[95:64];
            yaw_rate_reg <= s_tdata[127:96];
            meas_pos_reg <= s_tdata[159:128];
            meas_spd_reg <= s_tdata[191:160];
        end
        if (ctrl.step_load)
        begin
            step_reg <= step_next;
        end
        if (ctrl.slew_load)
        begin
            spd_reg <= spd_next;
        end
        if (ctrl.pos_load)
        begin
            pos_reg <= pos_next;
        end
        if (ctrl.finish)
        begin
            m_tdata_reg <= {yaw_target_reg, pos_final, spd_final};
        end
    end

endmodule

// ===== rtl/core/spsw_mul.sv =====
// Shared signed multiplier with a registered product.
module spsw_mul
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [spsw_pkg::MulAw-1:0]    a,
    input  logic signed [spsw_pkg::MulBw-1:0]    b,
    output logic signed [spsw_pkg::ProdW-1:0]    prod
);

    logic signed [spsw_pkg::ProdW-1:0] prod_reg;
    logic signed [spsw_pkg::ProdW-1:0] prod_next;

    assign prod_next = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/spsw_ctrl.sv =====
// Sequencer that walks one tick through the shared multiplier and update steps.
module spsw_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    output spsw_pkg::ctrl_t     ctrl
);

    spsw_pkg::state_t state_reg;
    spsw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spsw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = spsw_pkg::ST_MUL_STEP;
                end
            end
            spsw_pkg::ST_MUL_STEP: state_next = spsw_pkg::ST_STEP;
            spsw_pkg::ST_STEP:     state_next = spsw_pkg::ST_SLEW;
            spsw_pkg::ST_SLEW:     state_next = spsw_pkg::ST_MUL_POS;
            spsw_pkg::ST_MUL_POS:  state_next = spsw_pkg::ST_POS;
            spsw_pkg::ST_POS:      state_next = spsw_pkg::ST_WIN;
            spsw_pkg::ST_WIN:
            begin
                // hold until the result register can take the word
                if (out_free)
                begin
                    state_next = spsw_pkg::ST_IDLE;
                end
            end
            default:               state_next = spsw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        ctrl.mul_sel   = spsw_pkg::MUL_SEL_STEP;
        unique case (state_reg)
            spsw_pkg::ST_IDLE:
            begin
                ctrl.ready  = 1'b1;
                ctrl.accept = in_valid;
            end
            spsw_pkg::ST_MUL_STEP:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = spsw_pkg::MUL_SEL_STEP;
            end
            spsw_pkg::ST_STEP:
            begin
                ctrl.step_load = 1'b1;
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = spsw_pkg::MUL_SEL_YAW;
            end
            spsw_pkg::ST_SLEW:
            begin
                ctrl.slew_load = 1'b1;
            end
            spsw_pkg::ST_MUL_POS:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = spsw_pkg::MUL_SEL_POS;
            end
            spsw_pkg::ST_POS:
            begin
                ctrl.pos_load = 1'b1;
            end
            spsw_pkg::ST_WIN:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                ctrl.ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/spsw_checker.sv =====
// Port-level checks of the setpoint slew and window block, bound to the top level.
`include "setpoint_slew_and_window_top_assert.svh"

module spsw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata
);

    `SPSW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SPSW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `SPSW_ASSERT_NEXT(a_no_instant_result, clk, rst_n, s_tvalid && s_tready, !$rose(m_tvalid))
    `SPSW_ASSERT_NOW(a_idle_on_result, clk, rst_n, $rose(m_tvalid), s_tready)

endmodule

bind setpoint_slew_and_window_top spsw_checker u_spsw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
